>>> design/page_replacement_engine_top_macros.svh
// assertion helpers for the page replacement engine
`ifndef PAGE_REPLACEMENT_ENGINE_TOP_MACROS_SVH
`define PAGE_REPLACEMENT_ENGINE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define PRE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pre_pkg.sv
package pre_pkg;

    // default sizes
    localparam int DEF_PAGE_TABLE_ENTRIES = 65536;
    localparam int DEF_MAX_FRAMES         = 256;

    // configuration register indexes
    localparam logic [1:0] CFG_NUM_FRAMES = 2'd0;
    localparam logic [1:0] CFG_PAGE_SHIFT = 2'd1;
    localparam logic [1:0] CFG_POLICY     = 2'd2;

    // configuration reset values
    localparam logic [8:0] RST_NUM_FRAMES = 9'd4;
    localparam logic [4:0] RST_PAGE_SHIFT = 5'd8;
    localparam logic [1:0] RST_POLICY     = 2'd1;

    // victim choice codes
    localparam logic [1:0] POL_RANDOM = 2'd0;
    localparam logic [1:0] POL_FIFO   = 2'd1;
    localparam logic [1:0] POL_CLOCK  = 2'd2;

    // outcome codes
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    // 48-bit linear congruential generator
    localparam logic [47:0] LCG_SEED = 48'h0000_0001_330E;
    localparam logic [23:0] LCG_MUL_LO = 24'hECE66D;
    localparam logic [23:0] LCG_MUL_HI = 24'h0005DE;
    localparam logic [47:0] LCG_ADD = 48'hB;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    // width of a random draw and of a remainder dividend
    localparam int RND_W = 31;

    typedef logic [31:0] t_count;

endpackage

>>> design/pre_lcg.sv
module pre_lcg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_done,
    output logic [pre_pkg::RND_W-1:0] o_value
);
    import pre_pkg::*;

    logic [47:0] r_state;
    logic [47:0] r_acc;
    logic [47:0] r_prod;
    logic [2:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [23:0] mul_a;
    logic [23:0] mul_b;

    // one 24x24 multiplier, three partial products mod 2^48
    always_comb begin
        case (r_step)
            3'd0: begin
                mul_a = r_state[23:0];
                mul_b = LCG_MUL_LO;
            end
            3'd1: begin
                mul_a = r_state[47:24];
                mul_b = LCG_MUL_LO;
            end
            3'd2: begin
                mul_a = r_state[23:0];
                mul_b = LCG_MUL_HI;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LCG_SEED;
            r_busy  <= 1'b0;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == 3'd4);
            if (!r_busy) begin
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_step <= '0;
                end
            end else begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd4) begin
                    r_state <= r_acc + LCG_ADD;
                    r_busy  <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_step)
            3'd1:    r_acc <= r_prod;
            3'd2:    r_acc <= r_acc + {r_prod[23:0], 24'd0};
            3'd3:    r_acc <= r_acc + {r_prod[23:0], 24'd0};
            default: r_acc <= r_acc;
        endcase
    end

    assign o_done  = r_done;
    assign o_value = r_state[47:17];

endmodule

>>> design/pre_rem.sv
module pre_rem #(
    parameter int DW = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pre_pkg::RND_W-1:0] i_dividend,
    input  logic [DW-1:0]             i_divisor,
    output logic                      o_done,
    output logic [DW-1:0]             o_rem
);
    import pre_pkg::*;

    localparam int CW = $clog2(RND_W);

    logic [RND_W-1:0] r_dvd;
    logic [DW-1:0]    r_rem;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             fits;

    // restoring remainder, one dividend bit a cycle
    assign trial = {r_rem, r_dvd[RND_W-1]};
    assign fits  = trial >= {1'b0, i_divisor};
    assign diff  = trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(RND_W - 1));
            if (!r_busy) begin
                if (i_start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                end
            end else begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(RND_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
            r_rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> design/page_replacement_engine_top.sv
// channel   direction  signals                                         word
// in        slave      i_in_valid / o_in_ready, i_ref_address          one reference address
// out       master     o_out_valid / i_out_ready, o_outcome ...        one reference result
// cfg       slave      i_cfg_valid / o_cfg_ready, i_cfg_index/data     one register write
//
// a hit goes from lookup to decision to output, a fill into a free frame adds a fill
// state; a fifo eviction makes a remainder pass over the 31-bit dividend through the
// shared divider, then occupant read, table clear and fill; clock choice adds a check
// of each frame the hand passes, random choice first runs the 24x24 generator multiplier
// after reset the table is swept clear, one row a cycle, all PAGE_TABLE_ENTRIES rows,
// with o_in_ready low; config writes are taken at any time; one reference at a time
`include "page_replacement_engine_top_macros.svh"

module page_replacement_engine_top #(
    parameter int PAGE_TABLE_ENTRIES = pre_pkg::DEF_PAGE_TABLE_ENTRIES,
    parameter int MAX_FRAMES         = pre_pkg::DEF_MAX_FRAMES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_ref_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_outcome,
    output logic [7:0]  o_frame_number,
    output logic [15:0] o_victim_page,
    output pre_pkg::t_count o_requests_so_far,
    output pre_pkg::t_count o_faults_so_far,
    output pre_pkg::t_count o_swaps_so_far,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import pre_pkg::*;

    // table depth is taken as a power of two: the index is the low page bits
    localparam int IW  = (PAGE_TABLE_ENTRIES > 1) ? $clog2(PAGE_TABLE_ENTRIES) : 1;
    localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NFW = $clog2(MAX_FRAMES + 1);
    // table row: valid, recent, frame, full page tag
    localparam int EW  = 2 + FW + 32;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LOOK  = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_LCG   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_OCC   = 4'd6;
    localparam logic [3:0] S_OCCD  = 4'd7;
    localparam logic [3:0] S_CCHK  = 4'd8;
    localparam logic [3:0] S_EVICT = 4'd9;
    localparam logic [3:0] S_FILL  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    // config
    logic [8:0] r_num_frames;
    logic [4:0] r_page_shift;
    logic [1:0] r_policy;

    // control
    logic [3:0]     r_state, n_state;
    logic [IW-1:0]  r_clr_idx;
    logic [NFW-1:0] r_filled, n_filled;
    logic [FW-1:0]  r_fifo, n_fifo;
    logic [FW-1:0]  r_hand, n_hand;
    logic [NFW:0]   r_scan, n_scan;
    t_count         r_req_total, n_req_total;
    t_count         r_flt_total, n_flt_total;
    t_count         r_swp_total, n_swp_total;

    // per-reference payload
    logic [31:0]    r_page, n_page;
    logic [1:0]     r_outcome, n_outcome;
    logic [FW-1:0]  r_frame, n_frame;
    logic [IW-1:0]  r_victim, n_victim;

    // memories
    logic [EW-1:0]  r_ent_mem [PAGE_TABLE_ENTRIES];
    logic [IW-1:0]  r_occ_mem [MAX_FRAMES];
    logic [EW-1:0]  r_ent_rd;
    logic [IW-1:0]  r_occ_rd;
    logic           ent_we;
    logic [IW-1:0]  ent_waddr;
    logic [EW-1:0]  ent_wdata;
    logic [IW-1:0]  ent_raddr;
    logic           occ_we;
    logic [FW-1:0]  occ_waddr;
    logic [FW-1:0]  occ_raddr;

    // shared units
    logic             lcg_start;
    logic             lcg_done;
    logic [RND_W-1:0] lcg_value;
    logic             rem_start;
    logic [RND_W-1:0] rem_dividend;
    logic             rem_done;
    logic [NFW-1:0]   rem_out;

    logic [NFW-1:0] eff_nf;
    logic [IW-1:0]  r_idx;
    logic           ent_valid;
    logic           ent_recent;
    logic [FW-1:0]  ent_frame;
    logic [31:0]    ent_tag;
    logic [FW-1:0]  hand_next;
    logic [FW-1:0]  hand_next2;
    logic [NFW:0]   scan_next;

    function automatic logic [FW-1:0] wrap_inc(input logic [FW-1:0] f,
                                               input logic [NFW-1:0] nf);
        logic [31:0] nx;
        nx = 32'(f) + 32'd1;
        return (nx == 32'(nf)) ? '0 : FW'(nx);
    endfunction

    function automatic t_count sat_inc(input t_count v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

    // zero acts as one, beyond the frame store acts as full size
    always_comb begin
        if (r_num_frames == 9'd0) begin
            eff_nf = NFW'(1);
        end else if (32'(r_num_frames) > MAX_FRAMES) begin
            eff_nf = NFW'(MAX_FRAMES);
        end else begin
            eff_nf = NFW'(r_num_frames);
        end
    end

    assign r_idx      = r_page[IW-1:0];
    assign ent_valid  = r_ent_rd[EW-1];
    assign ent_recent = r_ent_rd[EW-2];
    assign ent_frame  = r_ent_rd[32 +: FW];
    assign ent_tag    = r_ent_rd[31:0];
    assign hand_next  = wrap_inc(r_hand, eff_nf);
    assign hand_next2 = wrap_inc(hand_next, eff_nf);
    assign scan_next  = r_scan + 1'b1;

    // config port, always open
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_frames <= RST_NUM_FRAMES;
            r_page_shift <= RST_PAGE_SHIFT;
            r_policy     <= RST_POLICY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NUM_FRAMES: r_num_frames <= i_cfg_data;
                CFG_PAGE_SHIFT: r_page_shift <= i_cfg_data[4:0];
                CFG_POLICY:     r_policy     <= i_cfg_data[1:0];
                default:        r_num_frames <= r_num_frames;
            endcase
        end
    end

    pre_lcg u_lcg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lcg_start),
        .o_done  (lcg_done),
        .o_value (lcg_value)
    );

    pre_rem #(.DW(NFW)) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (rem_dividend),
        .i_divisor  (eff_nf),
        .o_done     (rem_done),
        .o_rem      (rem_out)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_filled    = r_filled;
        n_fifo      = r_fifo;
        n_hand      = r_hand;
        n_scan      = r_scan;
        n_req_total = r_req_total;
        n_flt_total = r_flt_total;
        n_swp_total = r_swp_total;
        n_page      = r_page;
        n_outcome   = r_outcome;
        n_frame     = r_frame;
        n_victim    = r_victim;
        ent_we      = 1'b0;
        ent_waddr   = r_idx;
        ent_wdata   = '0;
        ent_raddr   = r_idx;
        occ_we      = 1'b0;
        occ_waddr   = r_frame;
        occ_raddr   = r_frame;
        lcg_start   = 1'b0;
        rem_start   = 1'b0;
        rem_dividend = RND_W'(r_fifo);

        case (r_state)
            S_CLR: begin
                ent_we    = 1'b1;
                ent_waddr = r_clr_idx;
                if (r_clr_idx == IW'(PAGE_TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_page      = i_ref_address >> r_page_shift;
                    n_req_total = sat_inc(r_req_total);
                    n_victim    = '0;
                    n_state     = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                if (ent_valid && ent_tag == r_page) begin
                    // hit: mark recent
                    n_outcome = OUT_HIT;
                    n_frame   = ent_frame;
                    ent_we    = 1'b1;
                    ent_wdata = {2'b11, ent_frame, ent_tag};
                    n_state   = S_OUT;
                end else if (ent_valid) begin
                    // aliased index: reload in place, no pointer moves
                    n_outcome   = OUT_EVICT;
                    n_frame     = ent_frame;
                    n_victim    = r_idx;
                    ent_we      = 1'b1;
                    ent_wdata   = {2'b10, ent_frame, r_page};
                    n_flt_total = sat_inc(r_flt_total);
                    n_swp_total = sat_inc(r_swp_total);
                    n_state     = S_OUT;
                end else if (r_filled < eff_nf) begin
                    n_outcome = OUT_FILL;
                    n_frame   = r_filled[FW-1:0];
                    n_filled  = r_filled + 1'b1;
                    n_state   = S_FILL;
                end else begin
                    n_outcome = OUT_EVICT;
                    if (r_policy == POL_RANDOM) begin
                        lcg_start = 1'b1;
                        n_state   = S_LCG;
                    end else begin
                        rem_start = 1'b1;
                        rem_dividend = (r_policy == POL_CLOCK) ? RND_W'(r_hand)
                                                               : RND_W'(r_fifo);
                        n_state   = S_DIV;
                    end
                end
            end
            S_LCG: begin
                if (lcg_done) begin
                    rem_start    = 1'b1;
                    rem_dividend = lcg_value;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                if (rem_done) begin
                    n_frame = FW'(rem_out);
                    // only the clock hand is folded into range
                    if (r_policy == POL_CLOCK) begin
                        n_hand = FW'(rem_out);
                    end
                    n_scan  = '0;
                    n_state = S_OCC;
                end
            end
            S_OCC: begin
                occ_raddr = (r_policy == POL_CLOCK) ? r_hand : r_frame;
                n_state   = S_OCCD;
            end
            S_OCCD: begin
                n_victim  = r_occ_rd;
                ent_raddr = r_occ_rd;
                n_state   = (r_policy == POL_CLOCK) ? S_CCHK : S_EVICT;
            end
            S_CCHK: begin
                if (!ent_recent) begin
                    n_frame = r_hand;
                    n_hand  = hand_next;
                    n_state = S_EVICT;
                end else begin
                    // second chance: clear the mark and move on
                    ent_we    = 1'b1;
                    ent_waddr = r_victim;
                    ent_wdata = {1'b1, 1'b0, r_ent_rd[EW-3:0]};
                    n_scan    = scan_next;
                    if (32'(scan_next) > 32'(eff_nf)) begin
                        n_frame = hand_next;
                        n_hand  = hand_next2;
                        n_state = S_EVICT;
                    end else begin
                        n_hand  = hand_next;
                        n_state = S_OCC;
                    end
                end
            end
            S_EVICT: begin
                ent_we      = 1'b1;
                ent_waddr   = r_victim;
                ent_wdata   = '0;
                n_flt_total = sat_inc(r_flt_total);
                n_swp_total = sat_inc(r_swp_total);
                n_state     = S_FILL;
            end
            S_FILL: begin
                ent_we    = 1'b1;
                ent_wdata = {2'b10, r_frame, r_page};
                occ_we    = 1'b1;
                n_fifo    = wrap_inc(r_frame, eff_nf);
                if (r_outcome == OUT_FILL) begin
                    n_flt_total = sat_inc(r_flt_total);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_idx   <= '0;
            r_filled    <= '0;
            r_fifo      <= '0;
            r_hand      <= '0;
            r_scan      <= '0;
            r_req_total <= '0;
            r_flt_total <= '0;
            r_swp_total <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= r_clr_idx + 1'b1;
            r_filled    <= n_filled;
            r_fifo      <= n_fifo;
            r_hand      <= n_hand;
            r_scan      <= n_scan;
            r_req_total <= n_req_total;
            r_flt_total <= n_flt_total;
            r_swp_total <= n_swp_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page    <= n_page;
        r_outcome <= n_outcome;
        r_frame   <= n_frame;
        r_victim  <= n_victim;
    end

    // page table rows
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[ent_waddr] <= ent_wdata;
        end
        r_ent_rd <= r_ent_mem[ent_raddr];
    end

    // frame occupants
    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            r_occ_mem[occ_waddr] <= r_idx;
        end
        r_occ_rd <= r_occ_mem[occ_raddr];
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = (r_state == S_OUT);
    assign o_outcome         = r_outcome;
    assign o_frame_number    = 8'(r_frame);
    assign o_victim_page     = 16'(r_victim);
    assign o_requests_so_far = r_req_total;
    assign o_faults_so_far   = r_flt_total;
    assign o_swaps_so_far    = r_swp_total;

    `PRE_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready,
        "input taken while a reference is in flight")
    `PRE_ASSERT_NOW(a_swaps_le_faults, 1'b1, r_swp_total <= r_flt_total,
        "swap total ran past fault total")
    `PRE_ASSERT_NOW(a_fill_bound, 1'b1, 32'(r_filled) <= MAX_FRAMES,
        "fill count beyond frame store")
    `PRE_ASSERT_NOW(a_hit_no_victim, o_out_valid && o_outcome == OUT_HIT,
        o_victim_page == 16'd0, "hit carries a victim page")
    `PRE_ASSERT_NOW(a_no_input_clearing, r_state == S_CLR, !o_in_ready && !o_out_valid,
        "channel open during table sweep")

endmodule

>>> tb/page_replacement_engine_top_tb.sv
module page_replacement_engine_top_tb;
    import pre_pkg::*;

    // one expected result word
    typedef struct packed {
        logic [1:0]  outcome;
        logic [7:0]  frame;
        logic [15:0] victim;
        logic [31:0] reqs;
        logic [31:0] faults;
        logic [31:0] swaps;
    } t_result;

    // scoreboard: paging predictor plus queue of pending result words
    class paging_scoreboard;
        bit          valid_q[65536];
        bit          recent_q[65536];
        logic [7:0]  frame_of[65536];
        logic [31:0] tag_of[65536];
        logic [15:0] occupant[256];
        int unsigned filled, fifo_ptr, hand;
        logic [47:0] rnd;
        logic [31:0] reqs, faults, swaps;
        logic [8:0]  nframes;
        logic [4:0]  shift;
        logic [1:0]  policy;
        t_result     pending[$];
        int          errors;

        function new();
            filled = 0; fifo_ptr = 0; hand = 0; rnd = LCG_SEED;
            reqs = 0; faults = 0; swaps = 0; errors = 0;
            nframes = RST_NUM_FRAMES; shift = RST_PAGE_SHIFT; policy = RST_POLICY;
        endfunction

        function void write_reg(logic [1:0] idx, logic [8:0] data);
            if (idx == CFG_NUM_FRAMES) nframes = data;
            else if (idx == CFG_PAGE_SHIFT) shift = data[4:0];
            else if (idx == CFG_POLICY) policy = data[1:0];
        endfunction

        function logic [31:0] sat(logic [31:0] v);
            return (v == CNT_MAX) ? v : v + 1;
        endfunction

        function int unsigned pick_victim(int unsigned nf);
            int unsigned v, n;
            logic [15:0] q;
            if (policy == POL_RANDOM) begin
                rnd = rnd * 48'h5DEECE66D + LCG_ADD;
                v = 32'(rnd >> 17) % nf;
            end else if (policy == POL_CLOCK) begin
                hand = hand % nf;
                for (n = 0; n <= nf; n++) begin
                    q = occupant[hand];
                    if (!recent_q[q]) break;
                    recent_q[q] = 0;
                    hand = (hand + 1) % nf;
                end
                v = hand;
                hand = (hand + 1) % nf;
            end else begin
                v = fifo_ptr % nf;
            end
            return v;
        endfunction

        // predict the result of one accepted reference
        function void note_ref(logic [31:0] addr);
            logic [31:0] page;
            logic [15:0] idx, q;
            int unsigned nf, fr;
            t_result r;
            page = addr >> shift;
            idx = page[15:0];
            nf = (nframes == 0) ? 1 : (nframes > 256 ? 256 : nframes);
            reqs = sat(reqs);
            r.victim = 0;
            if (valid_q[idx] && tag_of[idx] == page) begin
                r.outcome = OUT_HIT;
                r.frame = frame_of[idx];
                recent_q[idx] = 1;
            end else if (valid_q[idx]) begin
                // aliased index reloads in place
                r.outcome = OUT_EVICT;
                r.frame = frame_of[idx];
                r.victim = idx;
                tag_of[idx] = page;
                recent_q[idx] = 0;
                faults = sat(faults);
                swaps = sat(swaps);
            end else begin
                if (filled < nf) begin
                    r.outcome = OUT_FILL;
                    fr = filled;
                    filled++;
                    faults = sat(faults);
                end else begin
                    r.outcome = OUT_EVICT;
                    fr = pick_victim(nf);
                    q = occupant[fr];
                    r.victim = q;
                    valid_q[q] = 0;
                    recent_q[q] = 0;
                    faults = sat(faults);
                    swaps = sat(swaps);
                end
                r.frame = fr[7:0];
                fifo_ptr = (fr + 1) % nf;
                valid_q[idx] = 1;
                recent_q[idx] = 0;
                tag_of[idx] = page;
                frame_of[idx] = fr[7:0];
                occupant[fr] = idx;
            end
            r.reqs = reqs; r.faults = faults; r.swaps = swaps;
            pending.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp out=%0d fr=%0d vic=%0d r=%0d f=%0d s=%0d",
                              " / got out=%0d fr=%0d vic=%0d r=%0d f=%0d s=%0d"},
                        exp_r.outcome, exp_r.frame, exp_r.victim, exp_r.reqs, exp_r.faults,
                        exp_r.swaps, got.outcome, got.frame, got.victim, got.reqs,
                        got.faults, got.swaps);
            end
        endfunction
    endclass

    localparam int WATCHDOG = 200000;

    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_ready;
    logic [31:0] i_ref_address;
    logic        o_out_valid, i_out_ready;
    logic [1:0]  o_outcome;
    logic [7:0]  o_frame_number;
    logic [15:0] o_victim_page;
    t_count      o_requests_so_far, o_faults_so_far, o_swaps_so_far;
    logic        i_cfg_valid, o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [8:0]  i_cfg_data;

    paging_scoreboard sb;
    bit  calm;          // no idling in the last part of the run
    int  idle_cycles;   // cycles with no handshake at all

    page_replacement_engine_top dut (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
        calm = 0;
        idle_cycles = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_ref_address = 0;
        i_out_ready = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_NUM_FRAMES;
        i_cfg_data = 0;
    end

    // result side: random stall bursts, check each accepted word
    initial begin
        int burst;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 7);
                i_out_ready <= 0;
                repeat (burst) @(posedge i_clk);
            end
            i_out_ready <= 1;
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                sb.check_result({o_outcome, o_frame_number, o_victim_page,
                                 o_requests_so_far, o_faults_so_far, o_swaps_so_far});
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // write one register, only while the block is idle
    task automatic write_reg(logic [1:0] idx, logic [8:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    // send one reference word, with an optional gap first
    task automatic send_ref(logic [31:0] addr);
        if (!calm && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        i_in_valid <= 1;
        i_ref_address <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        i_in_valid <= 0;
        sb.note_ref(addr);
        // the block is busy after an accept
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_all(logic [8:0] nf, logic [4:0] sh, logic [1:0] pol);
        drain();
        write_reg(CFG_NUM_FRAMES, nf);
        write_reg(CFG_PAGE_SHIFT, {4'd0, sh});
        write_reg(CFG_POLICY, {7'd0, pol});
    endtask

    // random reference in a working set of pages, plus some noise
    function automatic logic [31:0] rand_addr(int unsigned span, logic [4:0] sh);
        logic [31:0] pg;
        if ($urandom_range(0, 9) == 0) return $urandom;
        pg = $urandom_range(0, span - 1);
        // occasionally alias onto the same table index
        if ($urandom_range(0, 7) == 0) pg = pg + (32'($urandom_range(1, 3)) << 16);
        return (pg << sh) | ($urandom & ((32'd1 << sh) - 1));
    endfunction

    initial begin
        logic [4:0] sh;
        int unsigned nf, span;
        logic [1:0] pol;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: defaults, hits in page, aliasing, fills and evictions
        send_ref(32'h0000_0000);
        send_ref(32'h0000_00FF);
        send_ref(32'hFFFF_FFFF);
        send_ref(32'h0100_0000);
        send_ref(32'h0000_0100);
        send_ref(32'h0000_0200);
        send_ref(32'h0000_0300);
        send_ref(32'h0000_0400);
        send_ref(32'h0000_0000);
        set_all(9'd0, 5'd0, POL_CLOCK);
        send_ref(32'h0000_0001);
        send_ref(32'h0000_0002);
        send_ref(32'h0001_0002);
        set_all(9'd511, 5'd31, 2'd3);
        send_ref(32'h8000_0000);
        send_ref(32'h7FFF_FFFF);
        set_all(9'd3, 5'd22, POL_RANDOM);
        send_ref(32'h0040_0000);
        send_ref(32'h0080_0000);
        send_ref(32'h00C0_0000);
        send_ref(32'h0100_0000);
        send_ref(32'hAAAA_AAAA);
        send_ref(32'h5555_5555);

        // random phases over several settings
        for (int ph = 0; ph < 9; ph++) begin
            nf = (ph == 3) ? 256 : (ph == 6 ? 1 : $urandom_range(1, 12));
            sh = (ph == 4) ? 5'd0 : (ph == 5 ? 5'd22 : 5'($urandom_range(0, 22)));
            pol = 2'($urandom_range(0, 3));
            if (ph == 7) calm = 1;
            set_all(9'(nf), sh, pol);
            span = nf + $urandom_range(1, 8);
            for (int k = 0; k < 48; k++) begin
                send_ref(rand_addr(span, sh));
                // lower the frame count mid-phase once, keeping pages resident
                if (ph == 2 && k == 24 && nf > 2) begin
                    drain();
                    write_reg(CFG_NUM_FRAMES, 9'(nf / 2));
                end
            end
        end

        drain();
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
